### rtl/gau_pkg.sv
// ----------------------------------------------------------------------------
// gau_pkg
// Shared types, constants and the sigmoid table of the gated activation unit.
// ----------------------------------------------------------------------------
package gau_pkg;

  localparam int DataWidth = 16;   // input field width
  localparam int FracBits  = 12;   // input fraction bits
  localparam int OutWidth  = 20;   // Q7.12 result width
  localparam int TabSize   = 256;  // sigmoid segments over [0, 16)
  localparam int SigFrac   = 24;   // sigmoid fraction bits
  localparam int Stages    = 10;   // pipeline depth

  // GELU constants in Q24
  localparam logic signed [20:0] GeluK  = 21'sd750193;
  localparam logic signed [25:0] GeluC2 = 26'sd26772564;

  typedef enum logic [1:0] {
    ACT_SILU  = 2'd0,
    ACT_GELU  = 2'd1,
    ACT_RELU  = 2'd2,
    ACT_IDENT = 2'd3
  } act_mode_e;

  typedef logic [SigFrac:0] sig_tab_t [0:TabSize];

  // Unsigned quotient by shift and subtract, used at elaboration only
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid table sigmoid(k*16/TabSize) in Q24, evaluated at elaboration
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t        tab;
    longint unsigned h;
    longint unsigned term;
    longint          acc;
    longint unsigned e;
    longint unsigned r;
    longint unsigned d;
    h    = (64'd16 << 30) / TabSize;
    term = 64'd1 << 30;
    acc  = 64'sd1 << 30;
    e    = 64'd1 << 30;
    for (int n = 1; n <= 24; n++) begin
      term = udiv((term * h) >> 30, 64'(n));
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    r = longint'(acc);
    for (int k = 0; k <= TabSize; k++) begin
      d      = (64'd1 << 30) + e;
      tab[k] = (SigFrac + 1)'(udiv((64'd1 << 54) + (d >> 1), d));
      e      = (e * r + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam sig_tab_t SigTab = build_sig_tab();

endpackage

### rtl/gau_in_if.sv
// ----------------------------------------------------------------------------
// gau_in_if
// Input channel: one element pair and its last flag per beat.
// ----------------------------------------------------------------------------
interface gau_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [gau_pkg::DataWidth-1:0]  x_value;
  logic signed [gau_pkg::DataWidth-1:0]  gate_value;
  logic                                  last_in;

  modport source (output valid, x_value, gate_value, last_in, input ready);
  modport sink   (input valid, x_value, gate_value, last_in, output ready);
endinterface

### rtl/gau_out_if.sv
// ----------------------------------------------------------------------------
// gau_out_if
// Output channel: one gated result and its last flag per beat.
// ----------------------------------------------------------------------------
interface gau_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gau_pkg::OutWidth-1:0]  gated_result;
  logic                                 last_out;

  modport source (output valid, gated_result, last_out, input ready);
  modport sink   (input valid, gated_result, last_out, output ready);
endinterface

### rtl/gated_activation_unit.sv
// ----------------------------------------------------------------------------
// gated_activation_unit
// Elementwise GLU activation: act(x) * gate, act chosen by act_mode.
// ----------------------------------------------------------------------------
// Usage:
//   in_s  : beats of (x_value, gate_value, last_in), signed Q3.12.
//   out_m : beats of (gated_result Q7.12, last_out), one per input beat,
//           in order.
//   act_mode_we_i / act_mode_i : writes the mode (SiLU, GELU, ReLU,
//           identity); write only while the pipeline is empty.
// Throughput is one beat per cycle while out_m is not stalled, set by a
// ten-stage pipeline with at most one multiplier per stage (GELU square
// and cube, polynomial, sigmoid interpolation, two scalings).
// When the receiver stalls, every stage holds and in_s.ready drops in the
// same cycle; nothing is lost or repeated, and the pipeline resumes at
// full rate once out_m.ready returns.
// Reset clears all stage valid bits and sets the mode to SiLU; no
// clearing pass is needed, the sigmoid table is a constant.
// ----------------------------------------------------------------------------
module gated_activation_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       act_mode_we_i,
  input  logic [1:0] act_mode_i,
  gau_in_if.sink     in_s,
  gau_out_if.source  out_m
);

  localparam int Dw = gau_pkg::DataWidth;
  localparam int Ns = gau_pkg::Stages;

  gau_pkg::act_mode_e mode_q;
  logic [Ns-1:0]      v_q;
  logic               adv;

  // payload that rides along every stage
  logic signed [Dw-1:0]     x_q    [Ns];
  logic signed [Dw-1:0]     g_q    [Ns];
  logic                     last_q [Ns];
  gau_pkg::act_mode_e       m_q    [Ns];

  // stage-specific payload
  logic signed [23:0] x2_q;
  logic signed [27:0] x3_q;
  logic signed [25:0] inner_q;
  logic signed [27:0] arg_q;
  logic        [24:0] lo_q, diff_q;
  logic        [11:0] fr_q;
  logic               neg_q, sat_q;
  logic        [24:0] s_q;
  logic signed [41:0] prod_q;
  logic signed [16:0] act_q;
  logic signed [gau_pkg::OutWidth-1:0] res_q;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= gau_pkg::ACT_SILU;
    end else if (act_mode_we_i) begin
      mode_q <= gau_pkg::act_mode_e'(act_mode_i);
    end
  end

  // global advance: the output register is free or being taken
  assign adv        = !v_q[Ns-1] || out_m.ready;
  assign in_s.ready = adv;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[Ns-2:0], in_s.valid};
    end
  end

  // common payload shift
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0]    <= in_s.x_value;
      g_q[0]    <= in_s.gate_value;
      last_q[0] <= in_s.last_in;
      m_q[0]    <= mode_q;
      for (int i = 1; i < Ns; i++) begin
        x_q[i]    <= x_q[i-1];
        g_q[i]    <= g_q[i-1];
        last_q[i] <= last_q[i-1];
        m_q[i]    <= m_q[i-1];
      end
    end
  end

  // Q16 view of x per stage
  function automatic logic signed [19:0] q16(input logic signed [Dw-1:0] v);
    return {v, 4'b0000};
  endfunction

  logic signed [39:0] sq_w;
  logic signed [43:0] cube_w;
  logic signed [48:0] kx3_w;
  logic signed [51:0] carg_w;
  logic signed [27:0] sarg_w;
  logic        [27:0] mag_w;
  logic        [36:0] interp_w;
  logic        [24:0] sig_w;
  logic signed [42:0] rnd_w;
  logic signed [17:0] sc_w;
  logic signed [16:0] act_w;
  logic signed [32:0] gp_w;
  logic signed [20:0] res_w;

  always_comb begin
    sq_w     = q16(x_q[0]) * q16(x_q[0]);
    cube_w   = x2_q * q16(x_q[1]);
    kx3_w    = gau_pkg::GeluK * x3_q;
    carg_w   = gau_pkg::GeluC2 * inner_q;
    sarg_w   = (m_q[4] == gau_pkg::ACT_SILU) ? 28'(q16(x_q[4])) : arg_q;
    mag_w    = sarg_w[27] ? 28'(-sarg_w) : 28'(sarg_w);
    interp_w = diff_q * fr_q;
    sig_w    = sat_q ? gau_pkg::SigTab[gau_pkg::TabSize]
                     : lo_q + 25'(interp_w >> 12);
    rnd_w    = 43'(prod_q) + 43'sd8388608;
    sc_w     = 18'(rnd_w >>> 24);
    unique case (m_q[7])
      gau_pkg::ACT_SILU:  act_w = 17'(sc_w);
      gau_pkg::ACT_GELU:  act_w = (x_q[7] == {1'b1, {(Dw-1){1'b0}}}) ? '0 : 17'(sc_w);
      gau_pkg::ACT_RELU:  act_w = x_q[7][Dw-1] ? '0 : 17'(x_q[7]);
      default:            act_w = 17'(x_q[7]);
    endcase
    gp_w  = act_q * g_q[8] + 33'sd2048;
    res_w = 21'(gp_w >>> 12);
  end

  // arithmetic stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_q    <= 24'(sq_w >>> 16);
      x3_q    <= 28'(cube_w >>> 16);
      inner_q <= 26'(q16(x_q[2])) + 26'(kx3_w >>> 24);
      arg_q   <= 28'(carg_w >>> 24);
      neg_q   <= sarg_w[27];
      sat_q   <= |mag_w[27:20];
      lo_q    <= gau_pkg::SigTab[{1'b0, mag_w[19:12]}];
      diff_q  <= gau_pkg::SigTab[9'(mag_w[19:12]) + 9'd1]
               - gau_pkg::SigTab[{1'b0, mag_w[19:12]}];
      fr_q    <= mag_w[11:0];
      s_q     <= neg_q ? (25'd16777216 - sig_w) : sig_w;
      prod_q  <= x_q[6] * $signed({1'b0, s_q});
      act_q   <= act_w;
      if (res_w > 21'sd524287)       res_q <= 20'sd524287;
      else if (res_w < -21'sd524288) res_q <= -20'sd524288;
      else                           res_q <= 20'(res_w);
    end
  end

  assign out_m.valid        = v_q[Ns-1];
  assign out_m.gated_result = res_q;
  assign out_m.last_out     = last_q[Ns-1];

  // checks
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_s.valid && in_s.ready |=> v_q[0])
    else $error("accepted beat did not enter pipeline");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipeline moved during stall");
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_m.valid) |-> $past(v_q[Ns-2]))
    else $error("output valid without upstream beat");

endmodule
